/* sv/imufd_pkg.sv */
package imufd_pkg;

  // Field widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned MAG_W   = RAW_W + 1;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned TEMP_W  = 17;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned TAG_W   = 5;

  // Tag codes carried in tag_byte[7:3]
  localparam logic [TAG_W-1:0] TAG_GYRO  = 5'h01;
  localparam logic [TAG_W-1:0] TAG_ACCEL = 5'h02;
  localparam logic [TAG_W-1:0] TAG_THERM = 5'h03;

  // Temperature offset: 25 C in Q8.8
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 17'sd6400;

  // Configuration register indexes and reset values
  localparam logic CFG_ACCEL_GAIN = 1'b0;
  localparam logic CFG_GYRO_GAIN  = 1'b1;
  localparam logic [SCALE_W-1:0] ACCEL_GAIN_RST = 32'd4523010;
  localparam logic [SCALE_W-1:0] GYRO_GAIN_RST  = 32'd5233397;

  // One axis ready for scaling: magnitude and final sign
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } lane_t;

  // Sample waiting for the multiply stage
  typedef struct packed {
    lane_t [2:0]               acc;
    lane_t [2:0]               gyr;
    logic signed [TEMP_W-1:0]  temp;
    logic [SEQ_W-1:0]          seq;
  } stage_t;

  // Split a raw axis into magnitude and sign, folding in the axis negation
  function automatic lane_t make_lane(input logic signed [RAW_W-1:0] raw,
                                      input logic negate);
    lane_t            l;
    logic [MAG_W-1:0] ext;
    ext   = {raw[RAW_W-1], raw};
    l.neg = raw[RAW_W-1] ^ negate;
    l.mag = raw[RAW_W-1] ? (MAG_W'(0) - ext) : ext;
    return l;
  endfunction

endpackage

/* sv/imufd_scale_lane.sv */
module imufd_scale_lane #(
  parameter int UP_SHIFT = 0
) (
  input  imufd_pkg::lane_t                          lane,
  input  logic [imufd_pkg::SCALE_W-1:0]             scale,
  output logic signed [imufd_pkg::OUT_W-1:0]        value
);

  localparam int PROD_W = imufd_pkg::MAG_W + imufd_pkg::SCALE_W;
  localparam int SH_W   = PROD_W + UP_SHIFT;
  localparam int OW     = imufd_pkg::OUT_W;

  localparam logic [SH_W-1:0] POS_LIM = SH_W'({1'b0, {(OW-1){1'b1}}});
  localparam logic [SH_W-1:0] NEG_LIM = SH_W'({1'b1, {(OW-1){1'b0}}});

  logic [PROD_W-1:0] prod;
  logic [SH_W-1:0]   shifted;
  logic [SH_W-1:0]   sat;
  logic [OW-1:0]     mag;

  // Magnitude times scale, aligned to 2^-32 units
  assign prod    = PROD_W'(lane.mag) * PROD_W'(scale);
  assign shifted = SH_W'(prod) << UP_SHIFT;

  // Clamp to the 48-bit range for the final sign
  always_comb begin
    if (lane.neg) begin
      sat = (shifted > NEG_LIM) ? NEG_LIM : shifted;
    end else begin
      sat = (shifted > POS_LIM) ? POS_LIM : shifted;
    end
  end

  assign mag   = sat[OW-1:0];
  assign value = lane.neg ? signed'(OW'(0) - mag) : signed'(mag);

endmodule

/* sv/imu_fifo_tag_pairing_decoder.sv */
// Tagged FIFO word decoder for a six-axis inertial sensor.
// Input channel (in_valid/in_ready): one FIFO word per request: drain_start,
// tag_byte and three signed 16-bit values. Tag 2 stores an accel triple,
// tag 1 a gyro triple, tag 3 the temperature; other tags store nothing.
// Output channel (out_valid/out_ready): one scaled sample per request, sent
// once both an accel and a gyro triple are pending.
// Config port: cfg_write/cfg_index/cfg_data writes the accel gain (index 0)
// or the gyro gain (index 1) on the clock edge; write only while idle.
// Pipeline: a word that completes a pair loads the pair register on its
// accepting edge; the multiply/saturate result loads the output register
// once that register is free or being taken. Throughput: one word per cycle
// while in_ready is high; the six 17x32 multipliers sit in their own stage,
// one per axis, so every cycle can start a new sample unless output stalls.
// Stall: while a sample waits on out_ready, one more sample can sit in the
// pair register; once that is full too, in_ready drops for every word until
// the output register is taken.
// Reset (rst, synchronous): clears pending marks, sample number and both
// pipeline stages, temperature returns to 25 C and scales to defaults.
module imu_fifo_tag_pairing_decoder #(
  parameter int SCALE_FRAC_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write,
  input  logic                                   cfg_index,
  input  logic [imufd_pkg::SCALE_W-1:0]          cfg_data,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   drain_start,
  input  logic [7:0]                             tag_byte,
  input  logic signed [imufd_pkg::RAW_W-1:0]     axis_x,
  input  logic signed [imufd_pkg::RAW_W-1:0]     axis_y,
  input  logic signed [imufd_pkg::RAW_W-1:0]     axis_z,
  // output samples
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [imufd_pkg::OUT_W-1:0]     accel_x,
  output logic signed [imufd_pkg::OUT_W-1:0]     accel_y,
  output logic signed [imufd_pkg::OUT_W-1:0]     accel_z,
  output logic signed [imufd_pkg::OUT_W-1:0]     gyro_x,
  output logic signed [imufd_pkg::OUT_W-1:0]     gyro_y,
  output logic signed [imufd_pkg::OUT_W-1:0]     gyro_z,
  output logic signed [imufd_pkg::TEMP_W-1:0]    temperature_q8,
  output logic [imufd_pkg::SEQ_W-1:0]            sample_number
);

  localparam int UP_SHIFT = 32 - SCALE_FRAC_BITS;
  localparam int RW = imufd_pkg::RAW_W;
  localparam int OW = imufd_pkg::OUT_W;

  // Scale registers
  logic [imufd_pkg::SCALE_W-1:0] accel_gain;
  logic [imufd_pkg::SCALE_W-1:0] gyro_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain <= imufd_pkg::ACCEL_GAIN_RST;
      gyro_gain  <= imufd_pkg::GYRO_GAIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        imufd_pkg::CFG_ACCEL_GAIN: accel_gain <= cfg_data;
        imufd_pkg::CFG_GYRO_GAIN:  gyro_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state
  logic signed [RW-1:0]                  pend_acc [3];
  logic signed [RW-1:0]                  pend_gyr [3];
  logic                                  accel_ready;
  logic                                  gyro_ready;
  logic signed [imufd_pkg::TEMP_W-1:0]   kept_temp;
  logic [imufd_pkg::SEQ_W-1:0]           seq_count;

  logic [imufd_pkg::TAG_W-1:0] tag;
  logic                        is_acc;
  logic                        is_gyr;
  logic                        is_temp;
  logic                        accept;
  logic                        acc_rdy_next;
  logic                        gyr_rdy_next;
  logic                        fire;
  logic signed [RW-1:0]        acc_raw [3];
  logic signed [RW-1:0]        gyr_raw [3];
  logic signed [imufd_pkg::TEMP_W-1:0] temp_next;

  // Pipeline control
  logic                  s1_valid;
  imufd_pkg::stage_t     s1;
  logic                  out_load;

  assign tag     = tag_byte[7:3];
  assign is_acc  = (tag == imufd_pkg::TAG_ACCEL);
  assign is_gyr  = (tag == imufd_pkg::TAG_GYRO);
  assign is_temp = (tag == imufd_pkg::TAG_THERM);
  assign accept  = in_valid && in_ready;

  // Pending marks after this word; a pair completes the sample
  assign acc_rdy_next = (accel_ready && !drain_start) || is_acc;
  assign gyr_rdy_next = (gyro_ready  && !drain_start) || is_gyr;
  assign fire         = acc_rdy_next && gyr_rdy_next;

  assign temp_next = is_temp ? (imufd_pkg::TEMP_W'(axis_x) + imufd_pkg::TEMP_OFFSET)
                             : kept_temp;

  // Triples as they stand after this word
  always_comb begin
    acc_raw[0] = is_acc ? axis_x : pend_acc[0];
    acc_raw[1] = is_acc ? axis_y : pend_acc[1];
    acc_raw[2] = is_acc ? axis_z : pend_acc[2];
    gyr_raw[0] = is_gyr ? axis_x : pend_gyr[0];
    gyr_raw[1] = is_gyr ? axis_y : pend_gyr[1];
    gyr_raw[2] = is_gyr ? axis_z : pend_gyr[2];
  end

  // State update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_ready <= 1'b0;
      gyro_ready  <= 1'b0;
      kept_temp   <= imufd_pkg::TEMP_OFFSET;
      seq_count   <= '0;
      for (int i = 0; i < 3; i++) begin
        pend_acc[i] <= '0;
        pend_gyr[i] <= '0;
      end
    end else if (accept) begin
      accel_ready <= acc_rdy_next && !fire;
      gyro_ready  <= gyr_rdy_next && !fire;
      kept_temp   <= temp_next;
      if (fire) begin
        seq_count <= seq_count + 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        pend_acc[i] <= acc_raw[i];
        pend_gyr[i] <= gyr_raw[i];
      end
    end
  end

  // Handshake: stage 1 moves on when the output register is free
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  // Stage 1: paired sample as magnitude and sign per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && fire) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      s1.acc[0] <= imufd_pkg::make_lane(acc_raw[0], 1'b0);
      s1.acc[1] <= imufd_pkg::make_lane(acc_raw[1], 1'b1);
      s1.acc[2] <= imufd_pkg::make_lane(acc_raw[2], 1'b1);
      s1.gyr[0] <= imufd_pkg::make_lane(gyr_raw[0], 1'b0);
      s1.gyr[1] <= imufd_pkg::make_lane(gyr_raw[1], 1'b1);
      s1.gyr[2] <= imufd_pkg::make_lane(gyr_raw[2], 1'b1);
      s1.temp   <= temp_next;
      s1.seq    <= seq_count;
    end
  end

  // Stage 2: multiply, saturate, sign
  logic signed [OW-1:0] acc_val [3];
  logic signed [OW-1:0] gyr_val [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    imufd_scale_lane #(.UP_SHIFT(UP_SHIFT)) u_acc (
      .lane  (s1.acc[g]),
      .scale (accel_gain),
      .value (acc_val[g])
    );
    imufd_scale_lane #(.UP_SHIFT(UP_SHIFT)) u_gyr (
      .lane  (s1.gyr[g]),
      .scale (gyro_gain),
      .value (gyr_val[g])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accel_x        <= acc_val[0];
      accel_y        <= acc_val[1];
      accel_z        <= acc_val[2];
      gyro_x         <= gyr_val[0];
      gyro_y         <= gyr_val[1];
      gyro_z         <= gyr_val[2];
      temperature_q8 <= s1.temp;
      sample_number  <= s1.seq;
    end
  end

`ifndef SYNTHESIS
  // Both marks are never left set together: a pair always emits
  a_no_stale_pair: assert property (@(posedge clk) disable iff (rst)
    !(accel_ready && gyro_ready))
    else $error("accel and gyro both pending after a step");

  // Sample number advances exactly on an emitting word
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (accept && fire) |=> (seq_count == $past(seq_count) + 1'b1))
    else $error("sequence count did not advance on emit");

  a_seq_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && fire) |=> $stable(seq_count))
    else $error("sequence count changed without emit");

  // An empty pair register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty pipeline");

  // A new output always comes from stage 1
  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output valid without stage 1 sample");
`endif

endmodule

/* tb/imufd_sample_check.sv */
module imufd_sample_check #(
  parameter int SCALE_FRAC_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [imufd_pkg::SCALE_W-1:0]       cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                drain_start,
  input  logic [7:0]                          tag_byte,
  input  logic signed [imufd_pkg::RAW_W-1:0]  axis_x,
  input  logic signed [imufd_pkg::RAW_W-1:0]  axis_y,
  input  logic signed [imufd_pkg::RAW_W-1:0]  axis_z,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [imufd_pkg::OUT_W-1:0]  accel_x,
  input  logic signed [imufd_pkg::OUT_W-1:0]  accel_y,
  input  logic signed [imufd_pkg::OUT_W-1:0]  accel_z,
  input  logic signed [imufd_pkg::OUT_W-1:0]  gyro_x,
  input  logic signed [imufd_pkg::OUT_W-1:0]  gyro_y,
  input  logic signed [imufd_pkg::OUT_W-1:0]  gyro_z,
  input  logic signed [imufd_pkg::TEMP_W-1:0] temperature_q8,
  input  logic [imufd_pkg::SEQ_W-1:0]         sample_number,
  output int                                  mismatches,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RW = imufd_pkg::RAW_W;
  localparam int OW = imufd_pkg::OUT_W;
  localparam int TW = imufd_pkg::TEMP_W;
  localparam int SW = imufd_pkg::SEQ_W;
  localparam int GW = imufd_pkg::SCALE_W;

  // left shift that brings raw*scale to 2^-32 units
  localparam int UP_SHIFT = (32 - SCALE_FRAC_BITS < 0) ? 0 :
                            (32 - SCALE_FRAC_BITS > 16) ? 16 : 32 - SCALE_FRAC_BITS;
  localparam logic [63:0] POS_CAP = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_CAP = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic signed [OW-1:0] ax;
    logic signed [OW-1:0] ay;
    logic signed [OW-1:0] az;
    logic signed [OW-1:0] gx;
    logic signed [OW-1:0] gy;
    logic signed [OW-1:0] gz;
    logic signed [TW-1:0] temp;
    logic [SW-1:0]        seq;
  } sample_t;

  sample_t              expected_samples[$];
  logic [GW-1:0]        accel_gain;
  logic [GW-1:0]        gyro_gain;
  logic signed [RW-1:0] accel_raw [0:2];
  logic signed [RW-1:0] gyro_raw [0:2];
  logic                 accel_marked;
  logic                 gyro_marked;
  logic signed [TW-1:0] temp_kept;
  logic [SW-1:0]        next_seq;

  // magnitude times gain, sign applied, clamped to 48 bits
  function automatic logic [OW-1:0] scaled_axis(input logic signed [RW-1:0] raw,
                                                input logic [GW-1:0] gain,
                                                input logic negate);
    logic [63:0] mag;
    logic        neg;
    neg = raw[RW-1] ^ negate;
    mag = raw[RW-1] ? 64'(-longint'(raw)) : 64'(longint'(raw));
    mag = (mag * {32'd0, gain}) << UP_SHIFT;
    if (neg) begin
      if (mag > NEG_CAP) mag = NEG_CAP;
      return OW'(64'd0 - mag);
    end
    if (mag > POS_CAP) mag = POS_CAP;
    return OW'(mag);
  endfunction

  // decode one accepted FIFO word, queue a sample once both triples are in
  function automatic void decode_word();
    sample_t s;
    if (drain_start) begin
      accel_marked = 1'b0;
      gyro_marked  = 1'b0;
    end
    case (tag_byte[7:3])
      imufd_pkg::TAG_ACCEL: begin
        accel_raw[0] = axis_x;
        accel_raw[1] = axis_y;
        accel_raw[2] = axis_z;
        accel_marked = 1'b1;
      end
      imufd_pkg::TAG_GYRO: begin
        gyro_raw[0] = axis_x;
        gyro_raw[1] = axis_y;
        gyro_raw[2] = axis_z;
        gyro_marked = 1'b1;
      end
      imufd_pkg::TAG_THERM: temp_kept = imufd_pkg::TEMP_OFFSET + {axis_x[RW-1], axis_x};
      default: ;
    endcase
    if (accel_marked && gyro_marked) begin
      s.ax   = scaled_axis(accel_raw[0], accel_gain, 1'b0);
      s.ay   = scaled_axis(accel_raw[1], accel_gain, 1'b1);
      s.az   = scaled_axis(accel_raw[2], accel_gain, 1'b1);
      s.gx   = scaled_axis(gyro_raw[0], gyro_gain, 1'b0);
      s.gy   = scaled_axis(gyro_raw[1], gyro_gain, 1'b1);
      s.gz   = scaled_axis(gyro_raw[2], gyro_gain, 1'b1);
      s.temp = temp_kept;
      s.seq  = next_seq;
      expected_samples.push_back(s);
      next_seq     = next_seq + 1'b1;
      accel_marked = 1'b0;
      gyro_marked  = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  function automatic void check_sample();
    sample_t want;
    if (expected_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t sample %0d arrived with none expected", $realtime, sample_number);
      return;
    end
    want = expected_samples.pop_front();
    check_field("accel_x", 64'(want.ax), 64'(accel_x));
    check_field("accel_y", 64'(want.ay), 64'(accel_y));
    check_field("accel_z", 64'(want.az), 64'(accel_z));
    check_field("gyro_x", 64'(want.gx), 64'(gyro_x));
    check_field("gyro_y", 64'(want.gy), 64'(gyro_y));
    check_field("gyro_z", 64'(want.gz), 64'(gyro_z));
    check_field("temperature_q8", 64'(want.temp), 64'(temperature_q8));
    check_field("sample_number", 64'(want.seq), 64'(sample_number));
  endfunction

  // watch both channels and the register port on every edge
  always @(posedge clk) begin
    if (rst) begin
      accel_gain   = imufd_pkg::ACCEL_GAIN_RST;
      gyro_gain    = imufd_pkg::GYRO_GAIN_RST;
      for (int i = 0; i < 3; i++) begin
        accel_raw[i] = '0;
        gyro_raw[i]  = '0;
      end
      accel_marked = 1'b0;
      gyro_marked  = 1'b0;
      temp_kept    = imufd_pkg::TEMP_OFFSET;
      next_seq     = '0;
      expected_samples.delete();
      mismatches   = 0;
      outstanding  = 0;
    end else begin
      if (out_valid && out_ready) check_sample();
      if (cfg_write) begin
        if (cfg_index == imufd_pkg::CFG_ACCEL_GAIN) accel_gain = cfg_data;
        else gyro_gain = cfg_data;
      end
      if (in_valid && in_ready) decode_word();
      outstanding = expected_samples.size();
    end
  end

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCALE_FRAC_BITS = 32;
  localparam int HOLD_CYCLES     = 150;
  localparam int SETTLE_CYCLES   = 6;
  localparam int PHASE_WORDS     = 180;

  localparam int RW = imufd_pkg::RAW_W;
  localparam int OW = imufd_pkg::OUT_W;
  localparam int TW = imufd_pkg::TEMP_W;
  localparam int SW = imufd_pkg::SEQ_W;
  localparam int GW = imufd_pkg::SCALE_W;
  localparam int KW = imufd_pkg::TAG_W;

  // tags the block ignores
  localparam logic [KW-1:0] TAG_NONE  = 5'h00;
  localparam logic [KW-1:0] TAG_SPARE = 5'h04;
  localparam logic [KW-1:0] TAG_TOP   = 5'h1F;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic                 cfg_index = imufd_pkg::CFG_ACCEL_GAIN;
  logic [GW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 drain_start = 1'b0;
  logic [7:0]           tag_byte = '0;
  logic signed [RW-1:0] axis_x = '0;
  logic signed [RW-1:0] axis_y = '0;
  logic signed [RW-1:0] axis_z = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OW-1:0] accel_x;
  logic signed [OW-1:0] accel_y;
  logic signed [OW-1:0] accel_z;
  logic signed [OW-1:0] gyro_x;
  logic signed [OW-1:0] gyro_y;
  logic signed [OW-1:0] gyro_z;
  logic signed [TW-1:0] temperature_q8;
  logic [SW-1:0]        sample_number;
  int                   mismatches;
  int                   outstanding;

  bit tx_fast  = 1'b0;
  bit rx_fast  = 1'b0;
  bit hold_off = 1'b0;

  imu_fifo_tag_pairing_decoder #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) uut (.*);

  imufd_sample_check #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) sample_check (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

  // sample receiver: random pause per sample, one long hold-off on request
  initial begin
    int pause;
    bit taken;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        pause = rx_fast ? 0 : $urandom_range(0, 11);
        if (pause > 0) begin
          out_ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        taken = out_valid;
        @(posedge clk);
      end
    end
  end

  // offer one FIFO word and hold it until the request is taken
  task automatic send_word(input logic ds, input logic [7:0] tag,
                           input logic signed [RW-1:0] x,
                           input logic signed [RW-1:0] y,
                           input logic signed [RW-1:0] z);
    int  gap;
    bit  accepted;
    gap = tx_fast ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    drain_start <= ds;
    tag_byte    <= tag;
    axis_x      <= x;
    axis_y      <= y;
    axis_z      <= z;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = in_ready;
      @(posedge clk);
    end
  endtask

  // stop offering and let every expected sample drain out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scales(input logic [GW-1:0] accel_val,
                              input logic [GW-1:0] gyro_val);
    cfg_write <= 1'b1;
    cfg_index <= imufd_pkg::CFG_ACCEL_GAIN;
    cfg_data  <= accel_val;
    @(posedge clk);
    cfg_index <= imufd_pkg::CFG_GYRO_GAIN;
    cfg_data  <= gyro_val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [RW-1:0] rand_axis();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return RW'($urandom);
    endcase
  endfunction

  // mostly accel/gyro words so pairs form often, some temp, drains and noise
  task automatic random_words(input int count);
    int                 pick;
    logic [KW-1:0]      tag;
    logic               ds;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) tag = imufd_pkg::TAG_ACCEL;
      else if (pick < 84) tag = imufd_pkg::TAG_GYRO;
      else if (pick < 92) tag = imufd_pkg::TAG_THERM;
      else if (pick < 94) tag = TAG_NONE;
      else tag = KW'($urandom_range(TAG_SPARE, TAG_TOP));
      ds = ($urandom_range(0, 19) == 0);
      send_word(ds, {tag, 3'($urandom)}, rand_axis(), rand_axis(), rand_axis());
    end
  endtask

  initial begin
    logic [GW-1:0] accel_set [0:6];
    logic [GW-1:0] gyro_set [0:6];
    logic [KW-1:0] t_acc;
    logic [KW-1:0] t_gyr;
    logic [KW-1:0] t_thm;
    accel_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, $urandom, $urandom,
                  imufd_pkg::ACCEL_GAIN_RST};
    gyro_set  = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, $urandom, $urandom,
                  imufd_pkg::GYRO_GAIN_RST};
    t_acc = imufd_pkg::TAG_ACCEL;
    t_gyr = imufd_pkg::TAG_GYRO;
    t_thm = imufd_pkg::TAG_THERM;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset scales
    send_word(1'b0, {t_thm, 3'b000}, 16'sh8000, 16'sh1234, 16'sh0000);   // coldest
    send_word(1'b0, {t_acc, 3'b111}, 16'sh7FFF, 16'sh8000, 16'sh0000);
    send_word(1'b0, {TAG_NONE, 3'b000}, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(1'b0, {TAG_TOP, 3'b111}, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(1'b0, {t_gyr, 3'b000}, 16'sh8000, 16'sh7FFF, 16'shFFFF);
    // repeated gyro replaces the pending one
    send_word(1'b0, {t_gyr, 3'b101}, 16'sd1, 16'sd2, 16'sd3);
    send_word(1'b0, {t_gyr, 3'b010}, 16'sd100, -16'sd100, 16'sd5);
    send_word(1'b0, {t_acc, 3'b000}, 16'shFFFF, 16'sh8000, 16'sh7FFF);
    send_word(1'b0, {t_thm, 3'b111}, 16'sh7FFF, 16'sh0000, 16'sh0000);   // hottest
    // drain start drops a half-formed pair
    send_word(1'b0, {t_acc, 3'b000}, 16'sd5, 16'sd6, 16'sd7);
    send_word(1'b1, {t_gyr, 3'b000}, 16'sd9, 16'sd10, 16'sd11);
    send_word(1'b1, {t_acc, 3'b011}, -16'sd20, 16'sd21, -16'sd22);
    send_word(1'b0, {t_gyr, 3'b100}, 16'sd30, -16'sd31, 16'sd32);
    send_word(1'b0, {t_thm, 3'b001}, 16'sh0000, 16'sh7FFF, 16'sh8000);
    send_word(1'b0, {TAG_SPARE, 3'b110}, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_word(1'b1, {t_acc, 3'b000}, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(1'b0, {t_gyr, 3'b111}, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(1'b0, {t_thm, 3'b111}, 16'shFFFF, 16'sh0001, 16'sh0001);
    send_word(1'b0, {t_gyr, 3'b000}, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(1'b0, {t_acc, 3'b000}, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    wait_idle();

    // random phases over a sweep of scale settings
    for (int p = 0; p < 7; p++) begin
      write_scales(accel_set[p], gyro_set[p]);
      tx_fast = (p % 3 == 1);
      rx_fast = (p % 3 == 2);
      random_words(PHASE_WORDS);
      wait_idle();
    end

    // receiver holds off while words keep coming back to back
    tx_fast  = 1'b1;
    rx_fast  = 1'b0;
    hold_off = 1'b1;
    random_words(100);
    tx_fast = 1'b0;
    wait_idle();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
